FILE: hw/rtl/sfs_pkg.sv
// ---------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer.
// ---------------------------------------------------------------------------
package sfs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_FORCE  = 2'd1,
        MODE_SELECT = 2'd2,
        MODE_LOAD   = 2'd3
    } sfs_mode_t;

    localparam logic [7:0] PERIOD_RESET = 8'd3;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        sfs_mode_t   mode;
        logic [2:0]  anim_select;
        logic        hold_last;
        logic [7:0]  frame_value;
        logic        last_entry;
    } sfs_item_t;

    typedef struct packed {
        logic [7:0]  frame;
        logic [3:0]  frame_index;
        logic [2:0]  current_anim;
        logic        anim_done;
        logic [3:0]  anim_count;
        logic        status;
    } sfs_result_t;

    typedef struct packed {
        logic frame_we;
        logic len_we;
    } sfs_wr_t;

endpackage

FILE: hw/rtl/sfs_store.sv
// ---------------------------------------------------------------------------
// sfs_store
// Frame table and sequence length table, one write and one registered
// read port each.
// ---------------------------------------------------------------------------
module sfs_store #(
    parameter int SAW  = 7,
    parameter int AIW  = 3,
    parameter int FBW  = 8,
    parameter int LPW  = 5,
    parameter int FDEP = 128,
    parameter int ADEP = 8
) (
    input  logic              clk,
    input  sfs_pkg::sfs_wr_t  wr,
    input  logic [SAW-1:0]    frame_waddr,
    input  logic [FBW-1:0]    frame_wdata,
    input  logic [SAW-1:0]    frame_raddr,
    output logic [FBW-1:0]    frame_rdata,
    input  logic [AIW-1:0]    len_waddr,
    input  logic [LPW-1:0]    len_wdata,
    input  logic [AIW-1:0]    len_raddr,
    output logic [LPW-1:0]    len_rdata
);

    logic [FBW-1:0] frame_mem [FDEP];
    logic [LPW-1:0] len_mem [ADEP];
    logic [FBW-1:0] frame_rdata_reg;
    logic [LPW-1:0] len_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_rdata_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata_reg <= len_mem[len_raddr];
    end

    assign frame_rdata = frame_rdata_reg;
    assign len_rdata   = len_rdata_reg;

endmodule

FILE: hw/rtl/sfs_core.sv
// ---------------------------------------------------------------------------
// sfs_core
// Sequencer control: takes one item, reads the active sequence length,
// updates the play and load state, reads the current frame and registers
// the result.
// ---------------------------------------------------------------------------
module sfs_core #(
    parameter int MAX_ANIMS  = 8,
    parameter int MAX_FRAMES = 16,
    parameter int FRAME_BITS = 8,
    parameter int SAW        = 7,
    parameter int AIW        = 3,
    parameter int FIW        = 4,
    parameter int LPW        = 5,
    parameter int CW         = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sfs_pkg::sfs_item_t    item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sfs_pkg::sfs_result_t  result,
    input  logic [7:0]            frame_period,
    output sfs_pkg::sfs_wr_t      wr,
    output logic [SAW-1:0]        frame_waddr,
    output logic [FRAME_BITS-1:0] frame_wdata,
    output logic [SAW-1:0]        frame_raddr,
    input  logic [FRAME_BITS-1:0] frame_rdata,
    output logic [AIW-1:0]        len_waddr,
    output logic [LPW-1:0]        len_wdata,
    output logic [AIW-1:0]        len_raddr,
    input  logic [LPW-1:0]        len_rdata
);

    localparam logic [SAW-1:0] FRAMES_A   = SAW'(MAX_FRAMES);
    localparam logic [LPW-1:0] FRAMES_L   = LPW'(MAX_FRAMES);
    localparam logic [CW-1:0]  ANIMS_C    = CW'(MAX_ANIMS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    sfs_pkg::sfs_item_t    item_reg;
    logic [CW-1:0]         total_reg, total_next;
    logic [LPW-1:0]        load_pos_reg, load_pos_next;
    logic                  load_failed_reg, load_failed_next;
    logic [7:0]            tick_reg, tick_next;
    logic [FIW-1:0]        pos_reg, pos_next;
    logic [2:0]            active_reg, active_next;
    logic                  hold_reg, hold_next;
    logic                  done_reg, done_next;
    logic                  status_reg, status_next;
    logic                  result_valid_reg;
    sfs_pkg::sfs_result_t  result_reg;
    logic [FIW:0]          pos_inc;
    logic                  load_bad;
    logic                  result_load;
    // the first sequence can write the frame that is read in the same cycle
    logic                  fwd_hit_reg;
    logic [FRAME_BITS-1:0] fwd_data_reg;

    // play and load state update, applied in the execute cycle
    always_comb
    begin
        total_next       = total_reg;
        load_pos_next    = load_pos_reg;
        load_failed_next = load_failed_reg;
        tick_next        = tick_reg;
        pos_next         = pos_reg;
        active_next      = active_reg;
        hold_next        = hold_reg;
        done_next        = done_reg;
        status_next      = sfs_pkg::STATUS_OK;
        wr               = '0;
        pos_inc          = (FIW + 1)'(pos_reg) + 1'b1;
        load_bad         = load_failed_reg || (load_pos_reg >= FRAMES_L);
        if (state_reg == ST_EXEC)
        begin
            case (item_reg.mode)
                sfs_pkg::MODE_TICK,
                sfs_pkg::MODE_FORCE:
                begin
                    if (total_reg == '0)
                    begin
                        if (item_reg.mode == sfs_pkg::MODE_FORCE)
                        begin
                            tick_next = frame_period;
                        end
                    end
                    else if (item_reg.mode == sfs_pkg::MODE_FORCE ||
                             (9'(tick_reg) + 9'd1 >= 9'(frame_period)))
                    begin
                        tick_next = '0;
                        if (pos_inc >= (FIW + 1)'(len_rdata))
                        begin
                            done_next = 1'b1;
                            if (hold_reg && len_rdata != '0)
                            begin
                                pos_next = FIW'(len_rdata - 1'b1);
                            end
                            else
                            begin
                                pos_next = '0;
                            end
                        end
                        else
                        begin
                            pos_next = FIW'(pos_inc);
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + 8'd1;
                    end
                end
                sfs_pkg::MODE_SELECT:
                begin
                    if (8'(item_reg.anim_select) >= 8'(total_reg))
                    begin
                        status_next = sfs_pkg::STATUS_REJECT;
                    end
                    else
                    begin
                        if (item_reg.anim_select != active_reg)
                        begin
                            active_next = item_reg.anim_select;
                            tick_next   = '0;
                            pos_next    = '0;
                            done_next   = 1'b0;
                        end
                        hold_next = item_reg.hold_last;
                    end
                end
                sfs_pkg::MODE_LOAD:
                begin
                    if (total_reg >= ANIMS_C)
                    begin
                        status_next      = sfs_pkg::STATUS_REJECT;
                        load_pos_next    = '0;
                        load_failed_next = 1'b0;
                    end
                    else
                    begin
                        if (load_bad)
                        begin
                            load_failed_next = 1'b1;
                            status_next      = sfs_pkg::STATUS_REJECT;
                        end
                        else
                        begin
                            wr.frame_we   = 1'b1;
                            load_pos_next = load_pos_reg + 1'b1;
                        end
                        if (item_reg.last_entry)
                        begin
                            if (!load_bad)
                            begin
                                wr.len_we  = 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                            load_pos_next    = '0;
                            load_failed_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    status_next = sfs_pkg::STATUS_OK;
                end
            endcase
        end
    end

    assign frame_waddr = SAW'(total_reg) * FRAMES_A + SAW'(load_pos_reg);
    assign frame_wdata = FRAME_BITS'(item_reg.frame_value);
    assign len_waddr   = AIW'(total_reg);
    assign len_wdata   = load_pos_reg + 1'b1;
    assign len_raddr   = AIW'(active_reg);
    assign frame_raddr = SAW'(active_next) * FRAMES_A + SAW'(pos_next);

    assign result_load = (state_reg == ST_OUT) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            total_reg        <= '0;
            load_pos_reg     <= '0;
            load_failed_reg  <= 1'b0;
            tick_reg         <= '0;
            pos_reg          <= '0;
            active_reg       <= '0;
            hold_reg         <= 1'b0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            total_reg       <= total_next;
            load_pos_reg    <= load_pos_next;
            load_failed_reg <= load_failed_next;
            tick_reg        <= tick_next;
            pos_reg         <= pos_next;
            active_reg      <= active_next;
            hold_reg        <= hold_next;
            done_reg        <= done_next;
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg   <= status_next;
            fwd_hit_reg  <= wr.frame_we && (frame_waddr == frame_raddr);
            fwd_data_reg <= frame_wdata;
        end
        if (result_load)
        begin
            result_reg.frame        <= (total_reg == '0) ? 8'd0 :
                                       fwd_hit_reg ? 8'(fwd_data_reg) : 8'(frame_rdata);
            result_reg.frame_index  <= 4'(pos_reg);
            result_reg.current_anim <= active_reg;
            result_reg.anim_done    <= done_reg;
            result_reg.anim_count   <= 4'(total_reg);
            result_reg.status       <= status_reg;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // table count never passes its capacity
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        8'(total_reg) <= 8'(MAX_ANIMS))
        else $error("animation count beyond table size");

    // load position stays within one sequence
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        8'(load_pos_reg) <= 8'(MAX_FRAMES))
        else $error("load position beyond sequence length");

    // the playing animation is always a committed one
    a_active_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> (8'(active_reg) < 8'(total_reg)))
        else $error("active animation not loaded");

    // once a sequence is committed a load never writes the row being played
    a_no_row_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.frame_we && total_reg != '0) |-> (8'(active_next) != 8'(total_reg)))
        else $error("frame write hits the playing sequence");

    // a new result only appears out of the output state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !$past(result_valid)) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

endmodule

FILE: hw/rtl/sprite_frame_sequencer.sv
// ---------------------------------------------------------------------------
// sprite_frame_sequencer
// Frame sequence table and player for sprite animation.
// ---------------------------------------------------------------------------
// An item is taken only in the idle state, once the last result is registered.
// The length of the playing sequence is read from its synchronous table while
// the item is taken in, the execute state updates the play and load state and
// reads the frame at the new position, and the output state writes the output
// register. These two dependent memory reads keep items from overlapping. A
// held result keeps the following item waiting at the output and stalls the
// item channel behind it. A frame that a load writes in the cycle it is read is
// forwarded to the result. The tables need no clearing after reset; a
// frame_period write of zero is ignored and cfg_ready is always high.
module sprite_frame_sequencer #(
    parameter int MAX_ANIMS  = 8,
    parameter int MAX_FRAMES = 16,
    parameter int FRAME_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sfs_pkg::sfs_item_t    item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sfs_pkg::sfs_result_t  result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    localparam int AIW  = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
    localparam int FIW  = $clog2(MAX_FRAMES);
    localparam int LPW  = $clog2(MAX_FRAMES + 1);
    localparam int CW   = $clog2(MAX_ANIMS + 1);
    localparam int FDEP = MAX_ANIMS * MAX_FRAMES;
    localparam int SAW  = $clog2(FDEP);

    logic [7:0]            period_reg;
    sfs_pkg::sfs_wr_t      wr;
    logic [SAW-1:0]        frame_waddr;
    logic [FRAME_BITS-1:0] frame_wdata;
    logic [SAW-1:0]        frame_raddr;
    logic [FRAME_BITS-1:0] frame_rdata;
    logic [AIW-1:0]        len_waddr;
    logic [LPW-1:0]        len_wdata;
    logic [AIW-1:0]        len_raddr;
    logic [LPW-1:0]        len_rdata;

    // frame period register, zero writes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= sfs_pkg::PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready && cfg_data != 8'd0)
        begin
            period_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    sfs_core #(
        .MAX_ANIMS  (MAX_ANIMS),
        .MAX_FRAMES (MAX_FRAMES),
        .FRAME_BITS (FRAME_BITS),
        .SAW        (SAW),
        .AIW        (AIW),
        .FIW        (FIW),
        .LPW        (LPW),
        .CW         (CW)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .frame_period (period_reg),
        .wr           (wr),
        .frame_waddr  (frame_waddr),
        .frame_wdata  (frame_wdata),
        .frame_raddr  (frame_raddr),
        .frame_rdata  (frame_rdata),
        .len_waddr    (len_waddr),
        .len_wdata    (len_wdata),
        .len_raddr    (len_raddr),
        .len_rdata    (len_rdata)
    );

    sfs_store #(
        .SAW  (SAW),
        .AIW  (AIW),
        .FBW  (FRAME_BITS),
        .LPW  (LPW),
        .FDEP (FDEP),
        .ADEP (MAX_ANIMS)
    ) u_store (
        .clk         (clk),
        .wr          (wr),
        .frame_waddr (frame_waddr),
        .frame_wdata (frame_wdata),
        .frame_raddr (frame_raddr),
        .frame_rdata (frame_rdata),
        .len_waddr   (len_waddr),
        .len_wdata   (len_wdata),
        .len_raddr   (len_raddr),
        .len_rdata   (len_rdata)
    );

endmodule
